// ===== rtl/bpi_pkg.sv =====
// Shared types and constants for the biomorph pixel iterator.
// Holds fixed-point widths, the payload structs and the controller/datapath command codes.
// No dependencies.
package bpi_pkg;

    // Frame geometry; both sizes must be powers of two
    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 1024;
    localparam int FW_LOG2      = $clog2(FRAME_WIDTH);
    localparam int FH_LOG2      = $clog2(FRAME_HEIGHT);
    localparam int HALF_W       = FRAME_WIDTH / 2;
    localparam int HALF_H       = FRAME_HEIGHT / 2;

    // Field widths
    localparam int PIX_W     = 11;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Q24.24 arithmetic
    localparam int Q_W     = 48;
    localparam int FRAC_W  = 24;
    localparam int ZOOM_W  = 47;
    localparam int ZLO_W   = 24;
    localparam int ZHI_W   = ZOOM_W - ZLO_W;
    localparam int OFF_W   = PIX_W + 2;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PSH_W   = PROD_W - FRAC_W;
    localparam int ACC_W   = OFF_W + ZOOM_W + 1;
    localparam int SMALL_W = MUL_W - 1;
    localparam int SQ_W    = 31;
    localparam int AB_W    = 32;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;
    // 70.0 squared-domain bailout: 70 << 48
    localparam logic [PROD_W-1:0] BAIL_SQ = PROD_W'(70) << (2 * FRAC_W);

    // Final escape thresholds: limit/5 via reciprocal, limit*20
    localparam int TRE_W  = 14;
    localparam int TIM_W  = 21;
    localparam int DIV5_W = 17;
    localparam int DIV5_SH = 18;
    localparam logic [DIV5_W-1:0] DIV5_MUL = 17'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZOOM      = 2'd0,
        CFG_CENTER_RE = 2'd1,
        CFG_CENTER_IM = 2'd2,
        CFG_LIMIT     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
        logic [CNT_W-1:0] iteration_count;
        logic             is_colored;
    } t_out;

    typedef struct packed {
        logic [ZOOM_W-1:0]       zoom_scale;
        logic signed [Q_W-1:0]   center_re;
        logic signed [Q_W-1:0]   center_im;
        logic [CNT_W-1:0]        iteration_limit;
        logic [TRE_W-1:0]        thr_re;
        logic [TIM_W-1:0]        thr_im;
    } t_cfg;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        M_XLO, M_XHI, M_YLO, M_YHI,
        M_AA, M_BB, M_AB,
        M_A2A2, M_A2B2, M_B2B2, M_ABD
    } t_mul;

    // Writeback selection for the registered product and the other datapath results
    typedef enum logic [3:0] {
        WB_NONE, WB_LOAD, WB_ACC_LO, WB_ACC_HI,
        WB_QX, WB_MAP_A, WB_QY, WB_MAP_B,
        WB_ASQ, WB_BSQ, WB_AB,
        WB_T0, WB_T1, WB_T2, WB_STEP, WB_OUT
    } t_wb;

    typedef struct packed {
        t_mul mul_sel;
        t_wb  wb_sel;
    } t_cmd;

    typedef struct packed {
        logic ina;
        logic inb;
        logic below_limit;
    } t_status;

endpackage

// ===== rtl/bpi_cfg_regs.sv =====
// Configuration registers of the biomorph pixel iterator.
// Also derives the final escape thresholds from the iteration limit. Uses bpi_pkg.
module bpi_cfg_regs import bpi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [Q_W-1:0]       i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [ZOOM_W-1:0]        r_zoom;
    logic signed [Q_W-1:0]    r_center_re;
    logic signed [Q_W-1:0]    r_center_im;
    logic [CNT_W-1:0]         r_limit;
    logic [TRE_W-1:0]         r_thr_re;
    logic [TIM_W-1:0]         r_thr_im;
    logic [CNT_W+DIV5_W-1:0]  div5_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom      <= ZOOM_W'(67108864);
            r_center_re <= '0;
            r_center_im <= '0;
            r_limit     <= CNT_W'(50);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ZOOM:      r_zoom      <= i_cfg_data[ZOOM_W-1:0];
                CFG_CENTER_RE: r_center_re <= $signed(i_cfg_data);
                CFG_CENTER_IM: r_center_im <= $signed(i_cfg_data);
                CFG_LIMIT:     r_limit     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // floor(limit / 5) exactly over the 16-bit range
    assign div5_prod = {{DIV5_W{1'b0}}, r_limit} * {{CNT_W{1'b0}}, DIV5_MUL};

    always_ff @(posedge i_clk) begin
        r_thr_re <= div5_prod[DIV5_SH +: TRE_W];
        r_thr_im <= TIM_W'({r_limit, 4'b0}) + TIM_W'({r_limit, 2'b0});
    end

    assign o_cfg.zoom_scale      = r_zoom;
    assign o_cfg.center_re       = r_center_re;
    assign o_cfg.center_im       = r_center_im;
    assign o_cfg.iteration_limit = r_limit;
    assign o_cfg.thr_re          = r_thr_re;
    assign o_cfg.thr_im          = r_thr_im;

endmodule

// ===== rtl/bpi_datapath.sv =====
// Datapath of the biomorph pixel iterator: one shared 33x33 multiplier and Q24.24 registers.
// Steered cycle by cycle by the command from bpi_ctrl. Uses bpi_pkg.
module bpi_datapath import bpi_pkg::*; (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    input  t_cfg    i_cfg,
    input  t_in     i_in,
    output t_status o_status,
    output t_out    o_out
);

    logic [PIX_W-1:0]          r_px;
    logic [PIX_W-1:0]          r_py;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_q;
    logic signed [Q_W-1:0]     r_a;
    logic signed [Q_W-1:0]     r_b;
    logic [SQ_W-1:0]           r_a2;
    logic [SQ_W-1:0]           r_b2;
    logic signed [AB_W-1:0]    r_ab;
    logic signed [AB_W-1:0]    r_diff;
    logic signed [Q_W-1:0]     r_t;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ina;
    logic                      r_inb;
    t_out                      r_out;

    logic signed [OFF_W-1:0]   off_x;
    logic signed [OFF_W-1:0]   off_y;
    logic [Q_W-1:0]            abs_a;
    logic [Q_W-1:0]            abs_b;
    logic                      small_a;
    logic                      small_b;
    logic signed [MUL_W-1:0]   op_x;
    logic signed [MUL_W-1:0]   op_y;
    logic signed [PSH_W-1:0]   prod_sh;
    logic signed [Q_W-1:0]     prod_q;
    logic signed [ACC_W-1:0]   acc_hi;
    logic signed [ACC_W-1:0]   acc_bx;
    logic signed [ACC_W-1:0]   acc_by;
    logic [Q_W-1:0]            thr_re_q;
    logic [Q_W-1:0]            thr_im_q;

    // Add the center offset and clamp to the Q24.24 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] q,
                                                    input logic signed [Q_W-1:0]   c);
        logic signed [ACC_W:0]  s;
        logic [ACC_W-Q_W+1:0]   hi;
        s  = $signed({q[ACC_W-1], q}) + $signed({{(ACC_W+1-Q_W){c[Q_W-1]}}, c});
        hi = s[ACC_W:Q_W-1];
        if (hi == '0 || hi == '1) begin
            sat_q = s[Q_W-1:0];
        end else if (s[ACC_W]) begin
            sat_q = Q_MIN;
        end else begin
            sat_q = Q_MAX;
        end
    endfunction

    assign off_x = $signed({{(OFF_W-PIX_W){1'b0}}, r_px}) - $signed(OFF_W'(HALF_W));
    assign off_y = $signed({{(OFF_W-PIX_W){1'b0}}, r_py}) - $signed(OFF_W'(HALF_H));

    assign abs_a   = r_a[Q_W-1] ? $unsigned(-r_a) : $unsigned(r_a);
    assign abs_b   = r_b[Q_W-1] ? $unsigned(-r_b) : $unsigned(r_b);
    assign small_a = (abs_a[Q_W-1:SMALL_W] == '0);
    assign small_b = (abs_b[Q_W-1:SMALL_W] == '0);

    always_comb begin
        op_x = '0;
        op_y = '0;
        case (i_cmd.mul_sel)
            M_XLO: begin
                op_x = {{(MUL_W-OFF_W){off_x[OFF_W-1]}}, off_x};
                op_y = {{(MUL_W-ZLO_W){1'b0}}, i_cfg.zoom_scale[ZLO_W-1:0]};
            end
            M_XHI: begin
                op_x = {{(MUL_W-OFF_W){off_x[OFF_W-1]}}, off_x};
                op_y = {{(MUL_W-ZHI_W){1'b0}}, i_cfg.zoom_scale[ZOOM_W-1:ZLO_W]};
            end
            M_YLO: begin
                op_x = {{(MUL_W-OFF_W){off_y[OFF_W-1]}}, off_y};
                op_y = {{(MUL_W-ZLO_W){1'b0}}, i_cfg.zoom_scale[ZLO_W-1:0]};
            end
            M_YHI: begin
                op_x = {{(MUL_W-OFF_W){off_y[OFF_W-1]}}, off_y};
                op_y = {{(MUL_W-ZHI_W){1'b0}}, i_cfg.zoom_scale[ZOOM_W-1:ZLO_W]};
            end
            M_AA: begin
                op_x = {1'b0, abs_a[SMALL_W-1:0]};
                op_y = {1'b0, abs_a[SMALL_W-1:0]};
            end
            M_BB: begin
                op_x = {1'b0, abs_b[SMALL_W-1:0]};
                op_y = {1'b0, abs_b[SMALL_W-1:0]};
            end
            M_AB: begin
                op_x = r_a[MUL_W-1:0];
                op_y = r_b[MUL_W-1:0];
            end
            M_A2A2: begin
                op_x = {{(MUL_W-SQ_W){1'b0}}, r_a2};
                op_y = {{(MUL_W-SQ_W){1'b0}}, r_a2};
            end
            M_A2B2: begin
                op_x = {{(MUL_W-SQ_W){1'b0}}, r_a2};
                op_y = {{(MUL_W-SQ_W){1'b0}}, r_b2};
            end
            M_B2B2: begin
                op_x = {{(MUL_W-SQ_W){1'b0}}, r_b2};
                op_y = {{(MUL_W-SQ_W){1'b0}}, r_b2};
            end
            M_ABD: begin
                op_x = {r_ab[AB_W-1], r_ab};
                op_y = {r_diff[AB_W-1], r_diff};
            end
            default: ;
        endcase
    end

    // Arithmetic shift of the signed product gives floor rounding
    assign prod_sh = r_prod[PROD_W-1:FRAC_W];
    assign prod_q  = Q_W'(prod_sh);
    assign acc_hi  = {r_prod[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

    // Bias negative sums so the shift truncates toward zero
    assign acc_bx = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << FW_LOG2) - 1) : ACC_W'(0));
    assign acc_by = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << FH_LOG2) - 1) : ACC_W'(0));

    assign thr_re_q = {{(Q_W-TRE_W-FRAC_W){1'b0}}, i_cfg.thr_re, {FRAC_W{1'b0}}};
    assign thr_im_q = {{(Q_W-TIM_W-FRAC_W){1'b0}}, i_cfg.thr_im, {FRAC_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(op_x) * PROD_W'(op_y);
        case (i_cmd.wb_sel)
            WB_LOAD: begin
                r_px    <= i_in.pixel_x;
                r_py    <= i_in.pixel_y;
                r_count <= '0;
            end
            WB_ACC_LO: r_acc <= r_prod[ACC_W-1:0];
            WB_ACC_HI: r_acc <= r_acc + acc_hi;
            WB_QX: begin
                r_q   <= acc_bx >>> FW_LOG2;
                r_acc <= r_prod[ACC_W-1:0];
            end
            WB_MAP_A: begin
                r_a   <= sat_q(r_q, i_cfg.center_re);
                r_acc <= r_acc + acc_hi;
            end
            WB_QY:    r_q <= acc_by >>> FH_LOG2;
            WB_MAP_B: r_b <= sat_q(r_q, i_cfg.center_im);
            WB_ASQ: begin
                r_ina <= small_a && ($unsigned(r_prod) < BAIL_SQ);
                r_a2  <= r_prod[FRAC_W +: SQ_W];
            end
            WB_BSQ: begin
                r_inb <= small_b && ($unsigned(r_prod) < BAIL_SQ);
                r_b2  <= r_prod[FRAC_W +: SQ_W];
            end
            WB_AB: begin
                r_ab   <= r_prod[FRAC_W +: AB_W];
                r_diff <= $signed({1'b0, r_a2}) - $signed({1'b0, r_b2});
            end
            WB_T0: r_t <= prod_q + ONE_Q;
            WB_T1: r_t <= r_t - ((prod_q <<< 2) + (prod_q <<< 1));
            WB_T2: r_t <= r_t + prod_q;
            WB_STEP: begin
                r_a     <= r_t;
                r_b     <= (prod_q <<< 2) + ONE_Q;
                r_count <= r_count + 1'b1;
            end
            WB_OUT: begin
                r_out.out_x           <= r_px;
                r_out.out_y           <= r_py;
                r_out.iteration_count <= r_count;
                r_out.is_colored      <= (abs_a > thr_re_q) || (abs_b > thr_im_q);
            end
            default: ;
        endcase
    end

    assign o_status.ina         = r_ina;
    assign o_status.inb         = r_inb;
    assign o_status.below_limit = (r_count < i_cfg.iteration_limit);
    assign o_out                = r_out;

endmodule

// ===== rtl/bpi_ctrl.sv =====
// Sequencer of the biomorph pixel iterator: maps the pixel, runs the z^4 + c loop,
// and owns both handshakes. Drives bpi_datapath through t_cmd. Uses bpi_pkg.
module bpi_ctrl import bpi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MX0, S_MX1, S_MX2, S_MX3, S_MX4, S_MX5, S_MX6,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.mul_sel = M_AA;
        o_cmd.wb_sel  = WB_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wb_sel = WB_LOAD;
                    n_state      = S_MX0;
                end
            end
            S_MX0: begin
                o_cmd.mul_sel = M_XLO;
                n_state       = S_MX1;
            end
            S_MX1: begin
                o_cmd.wb_sel  = WB_ACC_LO;
                o_cmd.mul_sel = M_XHI;
                n_state       = S_MX2;
            end
            S_MX2: begin
                o_cmd.wb_sel  = WB_ACC_HI;
                o_cmd.mul_sel = M_YLO;
                n_state       = S_MX3;
            end
            S_MX3: begin
                o_cmd.wb_sel  = WB_QX;
                o_cmd.mul_sel = M_YHI;
                n_state       = S_MX4;
            end
            S_MX4: begin
                o_cmd.wb_sel = WB_MAP_A;
                n_state      = S_MX5;
            end
            S_MX5: begin
                o_cmd.wb_sel = WB_QY;
                n_state      = S_MX6;
            end
            S_MX6: begin
                o_cmd.wb_sel = WB_MAP_B;
                n_state      = S_L0;
            end
            S_L0: begin
                o_cmd.mul_sel = M_AA;
                n_state       = S_L1;
            end
            S_L1: begin
                o_cmd.wb_sel  = WB_ASQ;
                o_cmd.mul_sel = M_BB;
                n_state       = S_L2;
            end
            S_L2: begin
                o_cmd.wb_sel  = WB_BSQ;
                o_cmd.mul_sel = M_AB;
                n_state       = S_L3;
            end
            S_L3: begin
                // bailout and limit test; start a^4 speculatively
                o_cmd.wb_sel  = WB_AB;
                o_cmd.mul_sel = M_A2A2;
                if (i_status.ina && i_status.inb && i_status.below_limit) begin
                    n_state = S_L4;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_L4: begin
                o_cmd.wb_sel  = WB_T0;
                o_cmd.mul_sel = M_A2B2;
                n_state       = S_L5;
            end
            S_L5: begin
                o_cmd.wb_sel  = WB_T1;
                o_cmd.mul_sel = M_B2B2;
                n_state       = S_L6;
            end
            S_L6: begin
                o_cmd.wb_sel  = WB_T2;
                o_cmd.mul_sel = M_ABD;
                n_state       = S_L7;
            end
            S_L7: begin
                o_cmd.wb_sel = WB_STEP;
                n_state      = S_L0;
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.wb_sel = WB_OUT;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MX0))
        else $error("accepted transaction did not start mapping");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result valid rose outside the final state");

    a_loop_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L3 && i_status.ina && i_status.inb && i_status.below_limit)
        |=> (r_state == S_L4))
        else $error("loop left while still inside bailout and limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("pending result overwritten");

endmodule

// ===== rtl/biomorph_pixel_iterator.sv =====
// Biomorph (z^4 + 1+1i) pixel iterator, Q24.24 fixed point.
// Each pixel is mapped, then the z^4 + c loop runs until bailout or the iteration limit;
// a new pixel is taken only from idle. The single shared 33x33 multiplier forms
// seven products per iteration and four per mapping. A finished result waits in the
// output register while the next pixel is taken. Synchronous active-low reset returns
// the sequencer to idle and loads the configuration defaults; no clearing pass.
module biomorph_pixel_iterator import bpi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [Q_W-1:0]       i_cfg_data
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    bpi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpi_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_cfg    (cfg),
        .i_in     (i_in_data),
        .o_status (status),
        .o_out    (o_out_data)
    );

    bpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for biomorph_pixel_iterator: pixel transactions with random gaps
// and output stalls, each result predicted in Q24.24 and compared field by field.
// Depends on bpi_pkg and the RTL top level only.
module tb_top;
    import bpi_pkg::*;

    localparam int     CYCLE_LIMIT   = 3_000_000;
    localparam int     MAX_RUN_ITERS = 64;
    localparam int     HOLD_OFF_LEN  = 300;
    localparam int     DRAIN_CYCLES  = 40;
    localparam longint Q_HI          = 64'sd140737488355327;
    localparam longint Q_LO          = -64'sd140737488355328;
    localparam longint ONE_FX        = 64'sd16777216;
    localparam logic [Q_W-1:0] ZOOM_RESET = 48'd67108864;
    localparam logic [Q_W-1:0] ZOOM_TOP   = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] CTR_MAX    = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] CTR_MIN    = {1'b1, {(Q_W-1){1'b0}}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data = '0;

    // Predictor copy of the view registers
    logic [ZOOM_W-1:0]     m_zoom;
    logic signed [Q_W-1:0] m_cre;
    logic signed [Q_W-1:0] m_cim;
    logic [CNT_W-1:0]      m_limit;

    t_out expected_pixels[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    bit   burst_mode = 1'b0;
    int   hold_off_req = 0;
    int   hold_off_seen = 0;
    int   hold_left = 0;
    int   rx_left = 0;
    bit   rx_stalled = 1'b0;

    biomorph_pixel_iterator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_pixels.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    // Floor-rounded Q24.24 product
    function automatic longint fx_mul(longint x, longint y);
        logic signed [127:0] xs;
        logic signed [127:0] ys;
        logic signed [127:0] p;
        xs = x;
        ys = y;
        p  = xs * ys;
        return longint'(p >>> FRAC_W);
    endfunction

    // v^2 < 70, exact
    function automatic bit in_bail(longint v);
        logic [63:0] m;
        logic [63:0] sq;
        m = (v < 0) ? -v : v;
        if (m >= 64'h1_0000_0000)
            return 1'b0;
        sq = m * m;
        return sq < (64'd70 << (2 * FRAC_W));
    endfunction

    function automatic longint map_axis(logic [PIX_W-1:0] pix, logic signed [Q_W-1:0] ctr,
                                        int frame);
        longint off;
        longint sum;
        off = longint'({53'd0, pix}) - longint'(frame / 2);
        // signed division truncates toward zero
        sum = (off * longint'({17'd0, m_zoom})) / longint'(frame) + longint'(ctr);
        if (sum > Q_HI)
            sum = Q_HI;
        else if (sum < Q_LO)
            sum = Q_LO;
        return sum;
    endfunction

    function automatic t_out predict_pixel(t_in px);
        longint a, b, a2, b2, ab, na, nb, mag_a, mag_b, thr_re, thr_im;
        int     count;
        int     lim;
        t_out   r;
        a     = map_axis(px.pixel_x, m_cre, FRAME_WIDTH);
        b     = map_axis(px.pixel_y, m_cim, FRAME_HEIGHT);
        lim   = int'(m_limit);
        count = 0;
        while (count < lim && in_bail(a) && in_bail(b)) begin
            a2 = fx_mul(a, a);
            b2 = fx_mul(b, b);
            ab = fx_mul(a, b);
            na = fx_mul(a2, a2) - 6 * fx_mul(a2, b2) + fx_mul(b2, b2) + ONE_FX;
            nb = 4 * fx_mul(ab, a2 - b2) + ONE_FX;
            a  = na;
            b  = nb;
            count++;
        end
        thr_re = longint'(10 * lim / 50) << FRAC_W;
        thr_im = longint'(1000 * lim / 50) << FRAC_W;
        mag_a  = (a < 0) ? -a : a;
        mag_b  = (b < 0) ? -b : b;
        r.out_x           = px.pixel_x;
        r.out_y           = px.pixel_y;
        r.iteration_count = CNT_W'(count);
        r.is_colored      = (mag_a > thr_re) || (mag_b > thr_im);
        return r;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time,
                         out_data.out_x, out_data.out_y);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_data.out_x !== want.out_x) begin
                    $display("%0t: out_x expected %0d, got %0d", $time,
                             want.out_x, out_data.out_x);
                    mismatches++;
                end
                if (out_data.out_y !== want.out_y) begin
                    $display("%0t: out_y expected %0d, got %0d", $time,
                             want.out_y, out_data.out_y);
                    mismatches++;
                end
                if (out_data.iteration_count !== want.iteration_count) begin
                    $display("%0t: iteration_count expected %0d, got %0d (pixel %0d,%0d)",
                             $time, want.iteration_count, out_data.iteration_count,
                             want.out_x, want.out_y);
                    mismatches++;
                end
                if (out_data.is_colored !== want.is_colored) begin
                    $display("%0t: is_colored expected %0b, got %0b (pixel %0d,%0d)",
                             $time, want.is_colored, out_data.is_colored,
                             want.out_x, want.out_y);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------

    always @(negedge clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            hold_left     = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall = 1'b1;
        end else begin
            if (rx_left == 0) begin
                if (rx_stalled) begin
                    rx_stalled = 1'b0;
                    rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 6);
                end else begin
                    rx_stalled = 1'b1;
                    rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
                end
            end
            rx_left--;
            out_stall = rx_stalled;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (burst_mode || r < 7)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_pixel(t_in px);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = px;
        do @(posedge clk); while (in_stall);
        expected_pixels.push_back(predict_pixel(px));
    endtask

    task automatic send_xy(int x, int y);
        t_in px;
        px.pixel_x = PIX_W'(x);
        px.pixel_y = PIX_W'(y);
        send_pixel(px);
    endtask

    function automatic t_in random_pixel();
        t_in p;
        if ($urandom_range(0, 3) == 0) begin
            p.pixel_x = PIX_W'($urandom_range(0, 2047));
            p.pixel_y = PIX_W'($urandom_range(0, 2047));
        end else begin
            p.pixel_x = PIX_W'($urandom_range(0, FRAME_WIDTH));
            p.pixel_y = PIX_W'($urandom_range(0, FRAME_HEIGHT));
        end
        return p;
    endfunction

    // Skip pixels whose orbit runs long, so high limits stay within the run budget
    task automatic send_random_pixel();
        t_in  px;
        t_out r;
        int   tries;
        tries = 0;
        do begin
            px = random_pixel();
            r  = predict_pixel(px);
            tries++;
        end while (r.iteration_count > MAX_RUN_ITERS && tries < 30);
        if (r.iteration_count <= MAX_RUN_ITERS)
            send_pixel(px);
    endtask

    task automatic finish_batch();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [Q_W-1:0] val);
        // drain first so no transaction is in flight during the write
        finish_batch();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_ZOOM:      m_zoom  = val[ZOOM_W-1:0];
            CFG_CENTER_RE: m_cre   = val;
            CFG_CENTER_IM: m_cim   = val;
            CFG_LIMIT:     m_limit = val[CNT_W-1:0];
        endcase
    endtask

    task automatic set_view(logic [Q_W-1:0] zoom, logic [Q_W-1:0] cre,
                            logic [Q_W-1:0] cim, logic [Q_W-1:0] lim);
        write_reg(CFG_ZOOM, zoom);
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
        write_reg(CFG_LIMIT, lim);
    endtask

    function automatic logic [Q_W-1:0] rand_wide();
        return Q_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [Q_W-1:0] rand_zoom();
        case ($urandom_range(0, 9))
            0:       return rand_wide();
            1:       return ZOOM_TOP;
            2:       return '0;
            default: return Q_W'($urandom_range(32'h0010_0000, 32'h0800_0000));
        endcase
    endfunction

    function automatic logic [Q_W-1:0] rand_center();
        case ($urandom_range(0, 9))
            0:       return rand_wide();
            1:       return CTR_MAX;
            2:       return CTR_MIN;
            default: return Q_W'(longint'($urandom_range(0, 32'h0400_0000)) - 64'sd33554432);
        endcase
    endfunction

    function automatic logic [Q_W-1:0] rand_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_W'(16'hFFFF);
            2:       return Q_W'($urandom_range(0, 65535));
            default: return Q_W'($urandom_range(1, 64));
        endcase
    endfunction

    // ---------------- tests ----------------

    // Reset values of the view: corners, center and pixels past the frame edge
    task automatic test_reset_view();
        send_xy(0, 0);
        send_xy(1024, 1024);
        send_xy(512, 512);
        send_xy(0, 1024);
        send_xy(1024, 0);
        send_xy(2047, 2047);
        send_xy(1365, 682);
        finish_batch();
    endtask

    // Odd zoom so negative offsets truncate toward zero
    task automatic test_mapping_rounding();
        write_reg(CFG_ZOOM, 48'd67108865);
        send_xy(511, 513);
        send_xy(0, 2047);
        write_reg(CFG_CENTER_RE, {Q_W{1'b1}});
        send_xy(511, 511);
        finish_batch();
    endtask

    // Start points outside the bailout, saturated mapping, zero zoom
    task automatic test_start_outside();
        set_view(ZOOM_TOP, '0, '0, 48'd50);
        send_xy(0, 0);
        write_reg(CFG_CENTER_RE, CTR_MAX);
        send_xy(2047, 512);
        write_reg(CFG_CENTER_RE, CTR_MIN);
        write_reg(CFG_CENTER_IM, CTR_MIN);
        send_xy(0, 0);
        write_reg(CFG_CENTER_RE, '0);
        write_reg(CFG_CENTER_IM, CTR_MAX);
        send_xy(512, 2047);
        set_view('0, '0, '0, 48'd50);
        send_xy(777, 3);
        finish_batch();
    endtask

    task automatic test_zero_limit();
        set_view(ZOOM_RESET, '0, '0, '0);
        send_xy(512, 512);
        send_xy(0, 0);
        send_xy(1024, 700);
        finish_batch();
    endtask

    task automatic test_high_limit();
        set_view(ZOOM_RESET, '0, '0, Q_W'(16'hFFFF));
        repeat (3) send_random_pixel();
        finish_batch();
        write_reg(CFG_LIMIT, 48'd1);
        send_xy(512, 512);
        send_xy(300, 800);
        finish_batch();
    endtask

    // Hold the output off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        set_view(ZOOM_RESET, '0, '0, 48'd20);
        hold_off_req++;
        burst_mode = 1'b1;
        repeat (20) send_random_pixel();
        burst_mode = 1'b0;
        finish_batch();
    endtask

    task automatic test_random_views();
        for (int phase = 0; phase < 11; phase++) begin
            set_view(rand_zoom(), rand_center(), rand_center(), rand_limit());
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (60) send_random_pixel();
            burst_mode = 1'b0;
            finish_batch();
        end
    endtask

    initial begin
        m_zoom  = ZOOM_RESET[ZOOM_W-1:0];
        m_cre   = '0;
        m_cim   = '0;
        m_limit = 16'd50;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_view();
        test_mapping_rounding();
        test_start_outside();
        test_zero_limit();
        test_high_limit();
        test_output_backpressure();
        test_random_views();

        finish_batch();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
